// File: sv/plgl_pkg.sv
// ---------------------------------------------------------------------------
// plgl_pkg
// Shared types, sizes and the CORDIC angle table for the ground lookup core.
// ---------------------------------------------------------------------------
package plgl_pkg;

    localparam int MaxSeg    = 16;
    localparam int IdxW      = 4;
    localparam int CntW      = 5;
    localparam int CoordW    = 24;
    localparam int AngW      = 16;
    localparam int CordW     = 44;
    localparam int CordSteps = 16;
    localparam int ProdW     = 49;
    localparam int DivCntW   = 6;
    localparam int StepW     = 5;

    typedef struct packed {
        logic [CoordW-1:0] sx;
        logic [CoordW-1:0] sy;
        logic [CoordW-1:0] ex;
        logic [CoordW-1:0] ey;
    } t_seg;

    typedef struct packed {
        logic            wr;
        logic            load_q;
        logic            rd;
        logic [IdxW-1:0] rd_addr;
        logic            seg_latch;
        logic            mul;
        logic            step;
        logic            out_load;
        logic            out_found;
    } t_cmd;

    typedef struct packed {
        logic ge_start;
        logic lt_end;
    } t_sts;

    // atan(2^-i) in Q2.13, rounded to nearest
    function automatic logic signed [AngW-1:0] atan_q13(input logic [3:0] i);
        logic signed [AngW-1:0] v;
        unique case (i)
            4'd0:    v = 16'sd6434;
            4'd1:    v = 16'sd3798;
            4'd2:    v = 16'sd2007;
            4'd3:    v = 16'sd1019;
            4'd4:    v = 16'sd511;
            4'd5:    v = 16'sd256;
            4'd6:    v = 16'sd128;
            4'd7:    v = 16'sd64;
            4'd8:    v = 16'sd32;
            4'd9:    v = 16'sd16;
            4'd10:   v = 16'sd8;
            4'd11:   v = 16'sd4;
            4'd12:   v = 16'sd2;
            4'd13:   v = 16'sd1;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/piecewise_linear_ground_lookup_core.sv
// ---------------------------------------------------------------------------
// piecewise_linear_ground_lookup_core
// Ground height and slope lookup over a table of up to 16 line segments.
// ---------------------------------------------------------------------------
// Input channel (i_valid/o_ready): i_mode 0 writes one segment at i_seg_index
// and gives no result; i_mode 1 queries ground at i_query_x. Output channel
// (o_valid/i_ready) carries o_found, o_ground_y (Q15.8) and o_slope_angle
// (Q2.13 radians). i_cfg_we/i_cfg_data load the segment count.
// A write beat leaves the block ready, so the next beat can follow at once.
// A query on an empty table goes straight to the output; otherwise the last
// entry is read first, and x at or past its end is a miss; else entries are
// scanned from entry 0, and a hit runs the multiply and then the bit-serial
// divider (49 steps) with the 16 CORDIC steps running beside it. The next
// beat is taken in the cycle the result turns valid.
// Results sit in an output register; while the receiver stalls, write beats
// are still taken, and a finished query waits until the register frees.
// Reset (synchronous, active low) clears the segment count and the handshake
// state; table entries are undefined until written.
// ---------------------------------------------------------------------------
module piecewise_linear_ground_lookup_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_mode,
    input  logic [plgl_pkg::IdxW-1:0]          i_seg_index,
    input  logic signed [plgl_pkg::CoordW-1:0] i_start_x,
    input  logic signed [plgl_pkg::CoordW-1:0] i_start_y,
    input  logic signed [plgl_pkg::CoordW-1:0] i_end_x,
    input  logic signed [plgl_pkg::CoordW-1:0] i_end_y,
    input  logic signed [plgl_pkg::CoordW-1:0] i_query_x,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_found,
    output logic signed [plgl_pkg::CoordW-1:0] o_ground_y,
    output logic signed [plgl_pkg::AngW-1:0]   o_slope_angle,
    input  logic                               i_cfg_we,
    input  logic [plgl_pkg::CntW-1:0]          i_cfg_data
);
    import plgl_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    plgl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_mode    (i_mode),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .o_cmd     (w_cmd),
        .i_sts     (w_sts)
    );

    plgl_dp u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_seg_index  (i_seg_index),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_query_x    (i_query_x),
        .o_found      (o_found),
        .o_ground_y   (o_ground_y),
        .o_slope_angle(o_slope_angle)
    );

    // a miss carries all-zero payload
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_ground_y == '0 && o_slope_angle == '0))
        else $error("miss result with nonzero payload");

    // a write beat leaves the block ready for the next beat
    a_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !i_mode) |=> o_ready)
        else $error("not ready after write beat");

    // a query beat occupies the sequencer
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_mode) |=> !o_ready)
        else $error("ready right after query beat");

endmodule

// File: sv/plgl_dp.sv
// ---------------------------------------------------------------------------
// plgl_dp
// Segment table, search compare, multiply, restoring divider, CORDIC and the
// result register.
// ---------------------------------------------------------------------------
module plgl_dp (
    input  logic                           i_clk,
    input  plgl_pkg::t_cmd                 i_cmd,
    output plgl_pkg::t_sts                 o_sts,
    input  logic [plgl_pkg::IdxW-1:0]      i_seg_index,
    input  logic signed [plgl_pkg::CoordW-1:0] i_start_x,
    input  logic signed [plgl_pkg::CoordW-1:0] i_start_y,
    input  logic signed [plgl_pkg::CoordW-1:0] i_end_x,
    input  logic signed [plgl_pkg::CoordW-1:0] i_end_y,
    input  logic signed [plgl_pkg::CoordW-1:0] i_query_x,
    output logic                           o_found,
    output logic signed [plgl_pkg::CoordW-1:0] o_ground_y,
    output logic signed [plgl_pkg::AngW-1:0]   o_slope_angle
);
    import plgl_pkg::*;

    t_seg                     r_mem [MaxSeg];
    t_seg                     r_rd;
    logic [CoordW-1:0]        r_qx;
    logic [CoordW-1:0]        r_a;
    logic [CoordW:0]          r_b;
    logic [CoordW-1:0]        r_d;
    logic                     r_neg;
    logic [CoordW-1:0]        r_sy;
    logic [ProdW-1:0]         r_pq;
    logic [CoordW-1:0]        r_rem;
    logic signed [CordW-1:0]  r_cx;
    logic signed [CordW-1:0]  r_cy;
    logic signed [AngW-1:0]   r_cz;
    logic [StepW-1:0]         r_ci;
    logic                     r_found;
    logic [CoordW-1:0]        r_gy;
    logic [AngW-1:0]          r_ang;

    logic signed [CoordW:0]   w_dx;
    logic signed [CoordW:0]   w_dy;
    logic signed [CoordW:0]   w_a;
    logic [CoordW:0]          w_sh;
    logic                     w_qbit;
    logic signed [CordW-1:0]  w_xs;
    logic signed [CordW-1:0]  w_ys;
    logic signed [CoordW+2:0] w_off;
    logic signed [CoordW+2:0] w_gy;

    assign o_sts.ge_start = $signed(r_qx) >= $signed(r_rd.sx);
    assign o_sts.lt_end   = $signed(r_qx) < $signed(r_rd.ex);

    assign w_dx = $signed({r_rd.ex[CoordW-1], r_rd.ex}) - $signed({r_rd.sx[CoordW-1], r_rd.sx});
    assign w_dy = $signed({r_rd.ey[CoordW-1], r_rd.ey}) - $signed({r_rd.sy[CoordW-1], r_rd.sy});
    assign w_a  = $signed({r_qx[CoordW-1], r_qx}) - $signed({r_rd.sx[CoordW-1], r_rd.sx});

    // one restoring step per beat of the sequencer
    assign w_sh   = {r_rem, r_pq[ProdW-1]};
    assign w_qbit = w_sh >= {1'b0, r_d};

    assign w_xs = r_cx >>> r_ci[3:0];
    assign w_ys = r_cy >>> r_ci[3:0];

    // quotient stays below 2^25
    assign w_off = r_neg ? -$signed({2'b00, r_pq[CoordW:0]}) : $signed({2'b00, r_pq[CoordW:0]});
    assign w_gy  = $signed({{3{r_sy[CoordW-1]}}, r_sy}) + w_off;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_seg_index] <= '{sx: i_start_x, sy: i_start_y, ex: i_end_x, ey: i_end_y};
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[i_cmd.rd_addr];
        end
        if (i_cmd.load_q) begin
            r_qx <= i_query_x;
        end
        if (i_cmd.seg_latch) begin
            r_a   <= w_a[CoordW-1:0];
            r_d   <= w_dx[CoordW-1:0];
            r_b   <= w_dy[CoordW] ? -w_dy : w_dy;
            r_neg <= w_dy[CoordW];
            r_sy  <= r_rd.sy;
            r_cx  <= $signed({{(CordW-CoordW-17){w_dx[CoordW]}}, w_dx, 16'b0});
            r_cy  <= $signed({{(CordW-CoordW-17){w_dy[CoordW]}}, w_dy, 16'b0});
            r_cz  <= '0;
            r_ci  <= '0;
        end
        if (i_cmd.mul) begin
            r_pq  <= ProdW'(r_a * r_b);
            r_rem <= '0;
        end
        if (i_cmd.step) begin
            r_rem <= w_qbit ? CoordW'(w_sh - {1'b0, r_d}) : w_sh[CoordW-1:0];
            r_pq  <= {r_pq[ProdW-2:0], w_qbit};
            if (r_ci != StepW'(CordSteps)) begin
                if (r_cy < 0) begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_cz <= r_cz - atan_q13(r_ci[3:0]);
                end else begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_cz <= r_cz + atan_q13(r_ci[3:0]);
                end
                r_ci <= r_ci + StepW'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_found <= i_cmd.out_found;
            r_gy    <= i_cmd.out_found ? w_gy[CoordW-1:0] : '0;
            r_ang   <= i_cmd.out_found ? r_cz : '0;
        end
    end

    assign o_found       = r_found;
    assign o_ground_y    = $signed(r_gy);
    assign o_slope_angle = $signed(r_ang);

endmodule

// File: sv/plgl_ctrl.sv
// ---------------------------------------------------------------------------
// plgl_ctrl
// Sequencer: table search, multiply/divide/CORDIC steps, result handoff.
// ---------------------------------------------------------------------------
module plgl_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_mode,
    output logic                      o_valid,
    input  logic                      i_ready,
    input  logic                      i_cfg_we,
    input  logic [plgl_pkg::CntW-1:0] i_cfg_data,
    output plgl_pkg::t_cmd            o_cmd,
    input  plgl_pkg::t_sts            i_sts
);
    import plgl_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LAST = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [CntW-1:0]    r_count;
    logic [IdxW-1:0]    r_idx, n_idx;
    logic [IdxW-1:0]    r_last, n_last;
    logic [DivCntW-1:0] r_cnt, n_cnt;
    logic               r_found, n_found;
    logic               r_ovalid, n_ovalid;
    logic [CntW-1:0]    w_neff;

    assign w_neff = (r_count > CntW'(MaxSeg)) ? CntW'(MaxSeg) : r_count;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_last   = r_last;
        n_cnt    = r_cnt;
        n_found  = r_found;
        n_ovalid = (r_ovalid && i_ready) ? 1'b0 : r_ovalid;
        o_cmd    = '0;
        o_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (!i_mode) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.load_q = 1'b1;
                        if (w_neff == '0) begin
                            n_found = 1'b0;
                            n_state = S_OUT;
                        end else begin
                            o_cmd.rd      = 1'b1;
                            o_cmd.rd_addr = IdxW'(w_neff - CntW'(1));
                            n_last        = IdxW'(w_neff - CntW'(1));
                            n_state       = S_LAST;
                        end
                    end
                end
            end
            S_LAST: begin
                if (!i_sts.lt_end) begin
                    n_found = 1'b0;
                    n_state = S_OUT;
                end else begin
                    o_cmd.rd      = 1'b1;
                    o_cmd.rd_addr = '0;
                    n_idx         = '0;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                // entry 0's start bounds the whole table
                priority if (r_idx == '0 && !i_sts.ge_start) begin
                    n_found = 1'b0;
                    n_state = S_OUT;
                end else if (i_sts.ge_start && i_sts.lt_end) begin
                    o_cmd.seg_latch = 1'b1;
                    n_state         = S_MUL;
                end else if (r_idx == r_last) begin
                    n_found = 1'b0;
                    n_state = S_OUT;
                end else begin
                    o_cmd.rd      = 1'b1;
                    o_cmd.rd_addr = r_idx + IdxW'(1);
                    n_idx         = r_idx + IdxW'(1);
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + DivCntW'(1);
                if (r_cnt == DivCntW'(ProdW - 1)) begin
                    n_found = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_found = r_found;
                    n_ovalid        = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
        end
        r_idx   <= n_idx;
        r_last  <= n_last;
        r_cnt   <= n_cnt;
        r_found <= n_found;
    end

    assign o_valid = r_ovalid;

endmodule

// File: verif/piecewise_linear_ground_lookup_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// piecewise_linear_ground_lookup_core_test
// Self-checking bench: a directed table of writes, count settings and queries,
// then random levels of mostly abutting segments with random queries and stray
// writes. Results are checked against a local ground model or a typed miss.
// ---------------------------------------------------------------------------
module piecewise_linear_ground_lookup_core_test;
    import plgl_pkg::*;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
    localparam int   SETTLE_CYC = 90;
    localparam int   STALL_LIMIT = 4000;
    localparam int   ITEM_GOAL = 420;

    typedef enum logic [1:0] {ROW_WR, ROW_QRY, ROW_CFG} t_row_kind;

    typedef struct {
        bit                found;
        logic [CoordW-1:0] gy;
        logic [AngW-1:0]   ang;
    } t_ground;

    typedef struct {
        t_row_kind         kind;
        logic [IdxW-1:0]   idx;
        logic [CoordW-1:0] sx, sy, ex, ey, qx;
        logic [CntW-1:0]   cnt;
        bit                typed;
        t_ground           want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_mode = 1'b0;
    logic [IdxW-1:0] i_seg_index = '0;
    logic signed [CoordW-1:0] i_start_x = '0, i_start_y = '0, i_end_x = '0, i_end_y = '0;
    logic signed [CoordW-1:0] i_query_x = '0;
    logic o_valid;
    logic i_ready = 1'b1;
    logic o_found;
    logic signed [CoordW-1:0] o_ground_y;
    logic signed [AngW-1:0] o_slope_angle;
    logic i_cfg_we = 1'b0;
    logic [CntW-1:0] i_cfg_data = '0;

    piecewise_linear_ground_lookup_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode), .i_seg_index(i_seg_index),
        .i_start_x(i_start_x), .i_start_y(i_start_y),
        .i_end_x(i_end_x), .i_end_y(i_end_y), .i_query_x(i_query_x),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_found(o_found), .o_ground_y(o_ground_y), .o_slope_angle(o_slope_angle),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // local copy of the level
    longint    lvl_sx[MaxSeg], lvl_sy[MaxSeg], lvl_ex[MaxSeg], lvl_ey[MaxSeg];
    int        lvl_count;
    t_ground   pending_ground[$];
    t_row      dir_rows[$];
    int        fail_cnt = 0;
    int        item_cnt = 0;
    bit        calm = 1'b0;

    function automatic longint sext(input logic [CoordW-1:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic void add_row(input t_row r);
        dir_rows = {dir_rows, r};
    endfunction

    function automatic t_ground ground_at(input logic [CoordW-1:0] qraw);
        t_ground  g;
        int       n;
        longint   qx, dx, dy, quo, cx, cy, cz, xs, ys;
        g = '{0, '0, '0};
        n = (lvl_count > MaxSeg) ? MaxSeg : lvl_count;
        qx = sext(qraw);
        if (n == 0 || qx < lvl_sx[0] || qx >= lvl_ex[n-1])
            return g;
        for (int i = 0; i < n; i++) begin
            if (qx >= lvl_sx[i] && qx < lvl_ex[i]) begin
                dx = lvl_ex[i] - lvl_sx[i];
                dy = lvl_ey[i] - lvl_sy[i];
                quo = ((qx - lvl_sx[i]) * (dy < 0 ? -dy : dy)) / dx;
                g.found = 1'b1;
                g.gy = CoordW'(lvl_sy[i] + (dy < 0 ? -quo : quo));
                // vectoring CORDIC, dx > 0 on any hit
                cx = dx <<< 16;
                cy = dy <<< 16;
                cz = 0;
                for (int k = 0; k < CordSteps; k++) begin
                    xs = cx >>> k;
                    ys = cy >>> k;
                    if (cy < 0) begin
                        cx = cx - ys; cy = cy + xs; cz = cz - atan_q13(4'(k));
                    end else begin
                        cx = cx + ys; cy = cy - xs; cz = cz + atan_q13(4'(k));
                    end
                end
                g.ang = AngW'(cz);
                return g;
            end
        end
        return g;
    endfunction

    task automatic send_beat(input logic mode, input logic [IdxW-1:0] idx,
                             input logic [CoordW-1:0] sx, input logic [CoordW-1:0] sy,
                             input logic [CoordW-1:0] ex, input logic [CoordW-1:0] ey,
                             input logic [CoordW-1:0] qx, input bit typed,
                             input t_ground want);
        t_ground exp_g;
        i_valid <= 1'b1;
        i_mode <= mode;
        i_seg_index <= idx;
        i_start_x <= sx; i_start_y <= sy; i_end_x <= ex; i_end_y <= ey;
        i_query_x <= qx;
        do @(posedge i_clk); while (!o_ready);
        item_cnt++;
        if (mode == MODE_QUERY) begin
            exp_g = typed ? want : ground_at(qx);
            pending_ground = {pending_ground, exp_g};
        end else begin
            lvl_sx[idx] = sext(sx); lvl_sy[idx] = sext(sy);
            lvl_ex[idx] = sext(ex); lvl_ey[idx] = sext(ey);
        end
        if (!calm && $urandom_range(3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // count is only written with the core idle
    task automatic set_count(input logic [CntW-1:0] cnt);
        i_valid <= 1'b0;
        wait (pending_ground.size() == 0);
        @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= cnt;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lvl_count = cnt;
    endtask

    function automatic t_row mk(input t_row_kind k, input int idx, input int sx,
                                input int sy, input int ex, input int ey, input int qx,
                                input int cnt, input bit typed);
        t_row r;
        r.kind = k; r.idx = IdxW'(idx); r.cnt = CntW'(cnt);
        r.sx = CoordW'(sx); r.sy = CoordW'(sy); r.ex = CoordW'(ex); r.ey = CoordW'(ey);
        r.qx = CoordW'(qx); r.typed = typed;
        r.want = '{0, '0, '0};     // typed rows here are all misses
        return r;
    endfunction

    // a level of ascending segments, mostly abutting, some gaps
    task automatic load_level();
        longint x, y, len;
        x = -4000000 - longint'($urandom_range(0, 4000000));
        y = longint'($urandom_range(0, 200000)) - 100000;
        for (int i = 0; i < MaxSeg; i++) begin
            logic [CoordW-1:0] sy_v;
            if ($urandom_range(7) == 0) x += $urandom_range(1, 600);
            len = ($urandom_range(9) == 0) ? $urandom_range(1, 262144) : $urandom_range(1, 4096);
            sy_v = CoordW'(y);
            if ($urandom_range(9) == 0) y = sext(CoordW'($urandom));
            else y += longint'($urandom_range(0, 8192)) - 4096;
            send_beat(MODE_WRITE, IdxW'(i), CoordW'(x), sy_v, CoordW'(x + len), CoordW'(y),
                      CoordW'($urandom), 0, '{0, '0, '0});
            x += len;
        end
    endtask

    always @(posedge i_clk) begin
        t_ground g;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_ground.size() == 0) begin
                $display("%0t: unexpected result found=%0d y=%0d ang=%0d",
                         $time, o_found, o_ground_y, o_slope_angle);
                fail_cnt++;
            end else begin
                g = pending_ground.pop_front();
                if (o_found !== g.found) begin
                    $display("%0t: found expected %0d actual %0d", $time, g.found, o_found);
                    fail_cnt++;
                end
                if (o_ground_y !== g.gy) begin
                    $display("%0t: ground_y expected %0d actual %0d", $time,
                             signed'(g.gy), o_ground_y);
                    fail_cnt++;
                end
                if (o_slope_angle !== g.ang) begin
                    $display("%0t: slope_angle expected %0d actual %0d", $time,
                             signed'(g.ang), o_slope_angle);
                    fail_cnt++;
                end
            end
        end
    end

    int stall_left = 0;
    always @(posedge i_clk) begin
        if (calm) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if ($urandom_range(7) == 0) begin
            stall_left <= $urandom_range(0, 8);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    int quiet_cyc = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            quiet_cyc <= 0;
        else
            quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc > STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_row r;
        int   pick;
        logic [CoordW-1:0] qx;

        add_row(mk(ROW_CFG, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk(ROW_QRY, 0, 0, 0, 0, 0, 0, 0, 1));           // empty table
        add_row(mk(ROW_WR, 0, -256, 0, 0, 0, 12345, 0, 0));      // flat
        add_row(mk(ROW_WR, 1, 0, 0, 256, 256, 0, 0, 0));
        add_row(mk(ROW_WR, 2, 256, 256, 8388607, -8388608, 0, 0, 0));
        add_row(mk(ROW_WR, 3, -8388608, 8388607, 8388607, -8388608, 0, 0, 0));
        add_row(mk(ROW_CFG, 0, 0, 0, 0, 0, 0, 3, 0));
        add_row(mk(ROW_QRY, 9, 1, 2, 3, 4, -257, 0, 1));         // before level
        add_row(mk(ROW_QRY, 0, 0, 0, 0, 0, -256, 0, 0));
        add_row(mk(ROW_QRY, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk(ROW_QRY, 0, 0, 0, 0, 0, 8388606, 0, 0));
        add_row(mk(ROW_QRY, 0, 0, 0, 0, 0, 8388607, 0, 1));      // at last end
        add_row(mk(ROW_CFG, 0, 0, 0, 0, 0, 0, 4, 0));
        add_row(mk(ROW_QRY, 0, 0, 0, 0, 0, -8388608, 0, 1));
        add_row(mk(ROW_QRY, 0, 0, 0, 0, 0, 100, 0, 0));          // first match wins
        add_row(mk(ROW_WR, 1, 0, 0, 128, -128, 0, 0, 0));        // opens a hole
        add_row(mk(ROW_CFG, 0, 0, 0, 0, 0, 0, 3, 0));
        add_row(mk(ROW_QRY, 0, 0, 0, 0, 0, 200, 0, 1));          // in the hole
        add_row(mk(ROW_QRY, 0, 0, 0, 0, 0, 64, 0, 0));           // falling slope

        lvl_count = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.kind == ROW_CFG)
                set_count(r.cnt);
            else
                send_beat(r.kind == ROW_QRY ? MODE_QUERY : MODE_WRITE, r.idx, r.sx, r.sy,
                          r.ex, r.ey, r.qx, r.typed, r.want);
        end

        load_level();
        for (int ph = 0; item_cnt < ITEM_GOAL; ph++) begin
            if (item_cnt > ITEM_GOAL - 80) calm = 1'b1;
            if (ph % 4 == 3) load_level();
            case (ph % 6)
                0: pick = 16;
                1: pick = 31;
                2: pick = 17;
                3: pick = 1;
                4: pick = (ph % 12 == 4) ? 0 : $urandom_range(1, 16);
                default: pick = $urandom_range(1, 16);
            endcase
            set_count(CntW'(pick));
            pick = (lvl_count > MaxSeg) ? MaxSeg : lvl_count;
            repeat (40) begin
                if ($urandom_range(9) == 0) begin
                    // stray write with arbitrary content
                    send_beat(MODE_WRITE, IdxW'($urandom), CoordW'($urandom), CoordW'($urandom),
                              CoordW'($urandom), CoordW'($urandom), CoordW'($urandom), 0,
                              '{0, '0, '0});
                end else begin
                    if ($urandom_range(11) == 0 || pick == 0)
                        qx = CoordW'($urandom);
                    else if (lvl_ex[pick-1] > lvl_sx[0] + 64)
                        qx = CoordW'(lvl_sx[0] - 64 + longint'($urandom_range(0,
                                int'(lvl_ex[pick-1] - lvl_sx[0] + 64))));
                    else
                        qx = CoordW'(lvl_sx[0] + longint'($urandom_range(0, 255)) - 128);
                    send_beat(MODE_QUERY, IdxW'($urandom), CoordW'($urandom), CoordW'($urandom),
                              CoordW'($urandom), CoordW'($urandom), qx, 0, '{0, '0, '0});
                end
            end
        end

        i_valid <= 1'b0;
        wait (pending_ground.size() == 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
